/* sv/cpf_pkg.sv */
// Package for the carrot path follower: payload structs, op codes, status codes,
// CORDIC arctangent table. No dependencies.
package cpf_pkg;

   localparam int CORDIC_STEPS = 24;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_POSE   = 2'd2,
      OP_CANCEL = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_MOVING    = 2'd0,
      ST_ARRIVED   = 2'd1,
      ST_ABORTED   = 2'd2,
      ST_CANCELLED = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CSR_LOOKAHEAD = 3'd0,
      CSR_GOAL_TOL  = 3'd1,
      CSR_BACKWARD  = 3'd2,
      CSR_FWD_LIN   = 3'd3,
      CSR_FWD_ANG   = 3'd4,
      CSR_BWD_LIN   = 3'd5,
      CSR_BWD_ANG   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [1:0]         operation;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [15:0]        robot_heading;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] linear_velocity;
      logic signed [15:0] angular_velocity;
      logic [1:0]         status;
      logic [7:0]         target_point;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SCAN_RD,
      BK_SCAN_CMP,
      BK_LAST_RD,
      BK_LAST_CMP,
      BK_CORDIC,
      BK_ERR,
      BK_MUL1,
      BK_MUL2,
      BK_ROUND,
      BK_OUT
   } back_state_type;

   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] v;
      case (i)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

/* sv/cpf_queue.sv */
// Short FIFO between the front and back halves of the follower.
// Depends on cpf_pkg for the request payload type.
module cpf_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cpf_pkg::req_payload_type push_data,
   output logic                     full,
   input  logic                     pop,
   output cpf_pkg::req_payload_type pop_data,
   output logic                     not_empty
);
   import cpf_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_payload_type  slot_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

   assign pop_data  = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (AW+1)'(DEPTH));

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

/* sv/cpf_back.sv */
// Back half: path store, target scan, CORDIC bearing, velocity law, result register.
// Depends on cpf_pkg for payload types, codes and the arctangent table.
module cpf_back #(
   parameter int MAX_POINTS = 256,
   parameter int ANGLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  cpf_pkg::req_payload_type item,
   output logic                     item_pop,
   input  logic [14:0]              lookahead_radius,
   input  logic [14:0]              goal_tolerance,
   input  logic                     backward_mode,
   input  logic signed [15:0]       forward_linear_gain,
   input  logic signed [15:0]       forward_angular_gain,
   input  logic signed [15:0]       backward_linear_gain,
   input  logic signed [15:0]       backward_angular_gain,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cpf_pkg::rsp_payload_type rsp_payload
);
   import cpf_pkg::*;

   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CW   = IW + 1;
   localparam int AB   = ANGLE_BITS;
   localparam int SH   = 32 - AB;
   localparam int UP   = (AB >= 16) ? AB - 16 : 0;
   localparam int DN   = (AB < 16) ? 16 - AB : 0;
   localparam int LSH  = 2 * AB - 2;
   localparam int ASH  = 20 + AB;
   localparam logic [22:0] TWO_PI_Q20 = 23'd6588397;
   localparam int PW   = 64;

   // state
   back_state_type      state_ff, state_in;
   logic [31:0]         store_mem [MAX_POINTS];
   logic [31:0]         rd_data_ff;
   logic [IW-1:0]       rd_addr;
   logic                rd_en;
   logic [CW-1:0]       count_ff, count_in;
   logic [IW-1:0]       target_ff, target_in;
   logic [1:0]          status_ff, status_in;

   // per-item working registers
   logic signed [15:0]  rx_ff, rx_in, ry_ff, ry_in;
   logic [15:0]         head_ff, head_in;
   logic signed [16:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic                arrive_ff, arrive_in;
   logic signed [26:0]  cx_ff, cx_in, cy_ff, cy_in;
   logic [31:0]         cz_ff, cz_in;
   logic [4:0]          step_ff, step_in;
   logic signed [AB:0]  phi_ff, phi_in;
   logic signed [PW-1:0] lin_ff, lin_in, ang_ff, ang_in;
   logic signed [15:0]  lin_out_ff, lin_out_in, ang_out_ff, ang_out_in;

   // result register
   logic                out_valid_ff, out_valid_in;
   rsp_payload_type     out_ff, out_in;

   // combinational helpers
   logic signed [16:0]  pdx, pdy;
   logic [33:0]         d2;
   logic [29:0]         rad2, tol2;
   logic [IW-1:0]       last_idx;
   logic signed [26:0]  sx, sy;
   logic [AB-1:0]       theta, h, phi_u, half_u;
   logic [31:0]         zr;
   logic signed [AB:0]  phi_s, mag, rr;
   logic signed [15:0]  lg, ag;

   assign last_idx = IW'(count_ff - 1'b1);
   assign pdx  = 17'(signed'(rd_data_ff[15:0])) - 17'(rx_ff);
   assign pdy  = 17'(signed'(rd_data_ff[31:16])) - 17'(ry_ff);
   assign d2   = 34'(pdx * pdx) + 34'(pdy * pdy);
   assign rad2 = 30'(lookahead_radius * lookahead_radius);
   assign tol2 = 30'(goal_tolerance * goal_tolerance);
   assign sx   = cx_ff >>> step_ff;
   assign sy   = cy_ff >>> step_ff;
   assign half_u = AB'(1) << (AB - 1);
   assign lg = backward_mode ? backward_linear_gain : forward_linear_gain;
   assign ag = backward_mode ? backward_angular_gain : forward_angular_gain;

   always_comb begin
      zr    = cz_ff + (32'd1 << (SH - 1));
      theta = (dx_ff == 0 && dy_ff == 0) ? '0 : AB'(zr >> SH);
      if (DN > 0) h = AB'((17'(head_ff) + (17'd1 << (DN > 0 ? DN - 1 : 0))) >> DN);
      else        h = AB'(32'(head_ff) << UP);
      phi_u = theta - h;
      if (backward_mode) phi_u = half_u - phi_u;
      phi_s = (phi_u > half_u) ? $signed({1'b0, phi_u}) - $signed({1'b1, {AB{1'b0}}})
                               : $signed({1'b0, phi_u});
      mag   = (phi_ff < 0) ? -phi_ff : phi_ff;
      rr    = $signed({1'b0, half_u}) - mag;
   end

   function automatic logic signed [15:0] round_sat(input logic signed [PW-1:0] v,
                                                    input int s);
      logic signed [PW-1:0] t;
      t = (v + (PW'(1) <<< (s - 1))) >>> s;
      if (t > 32767) return 16'sh7FFF;
      if (t < -32768) return -16'sh8000;
      return t[15:0];
   endfunction

   // read port of the store
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = target_ff;
      case (state_ff)
         BK_SCAN_RD: begin
            rd_en = 1'b1;
            rd_addr = target_ff;
         end
         BK_LAST_RD: begin
            rd_en = 1'b1;
            rd_addr = last_idx;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= store_mem[rd_addr];
      if (state_ff == BK_IDLE && item_valid && item.operation == OP_APPEND
          && count_ff < CW'(MAX_POINTS)) begin
         store_mem[IW'(count_ff)] <= {item.pos_y, item.pos_x};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               if (item.operation == OP_POSE && status_ff == ST_MOVING
                   && count_ff > CW'(1)) state_in = BK_SCAN_RD;
               else if (item.operation == OP_POSE || item.operation == OP_CANCEL)
                  state_in = BK_OUT;
            end
         end
         BK_SCAN_RD:  state_in = BK_SCAN_CMP;
         BK_SCAN_CMP: begin
            if (target_ff < last_idx && d2 < 34'(rad2)) state_in = BK_SCAN_RD;
            else state_in = BK_LAST_RD;
         end
         BK_LAST_RD:  state_in = BK_LAST_CMP;
         BK_LAST_CMP: state_in = BK_CORDIC;
         BK_CORDIC:   if (step_ff == 5'(CORDIC_STEPS - 1)) state_in = BK_ERR;
         BK_ERR:      state_in = BK_MUL1;
         BK_MUL1:     state_in = BK_MUL2;
         BK_MUL2:     state_in = BK_ROUND;
         BK_ROUND:    state_in = BK_OUT;
         BK_OUT:      if (!out_valid_ff || !rsp_stall) state_in = BK_IDLE;
         default:     state_in = BK_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      count_in   = count_ff;
      target_in  = target_ff;
      status_in  = status_ff;
      rx_in      = rx_ff;
      ry_in      = ry_ff;
      head_in    = head_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      arrive_in  = arrive_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      step_in    = step_ff;
      phi_in     = phi_ff;
      lin_in     = lin_ff;
      ang_in     = ang_ff;
      lin_out_in = lin_out_ff;
      ang_out_in = ang_out_ff;
      item_pop   = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (item_valid) begin
               item_pop   = 1'b1;
               rx_in      = item.pos_x;
               ry_in      = item.pos_y;
               head_in    = item.robot_heading;
               lin_out_in = '0;
               ang_out_in = '0;
               case (item.operation)
                  OP_CLEAR: begin
                     count_in  = '0;
                     target_in = '0;
                     status_in = ST_MOVING;
                  end
                  OP_APPEND: begin
                     if (count_ff < CW'(MAX_POINTS)) count_in = count_ff + 1'b1;
                  end
                  OP_CANCEL: begin
                     if (status_ff == ST_MOVING) status_in = ST_CANCELLED;
                  end
                  OP_POSE: begin
                     if (status_ff == ST_MOVING) begin
                        if (count_ff <= CW'(1)) status_in = ST_ABORTED;
                        else if (CW'(target_ff) > CW'(last_idx)) target_in = last_idx;
                     end
                  end
                  default: ;
               endcase
            end
         end
         BK_SCAN_CMP: begin
            if (target_ff < last_idx && d2 < 34'(rad2)) target_in = target_ff + 1'b1;
            else begin
               dx_in = pdx;
               dy_in = pdy;
            end
         end
         BK_LAST_CMP: begin
            arrive_in = (d2 <= 34'(tol2));
            step_in   = '0;
            if (dx_ff < 0) begin
               cx_in = -(27'(dx_ff) <<< 8);
               cy_in = -(27'(dy_ff) <<< 8);
               cz_in = 32'h80000000;
            end else begin
               cx_in = 27'(dx_ff) <<< 8;
               cy_in = 27'(dy_ff) <<< 8;
               cz_in = '0;
            end
         end
         BK_CORDIC: begin
            step_in = step_ff + 1'b1;
            if (cy_ff > 0) begin
               cx_in = cx_ff + sy;
               cy_in = cy_ff - sx;
               cz_in = cz_ff + atan_turn(step_ff);
            end else begin
               cx_in = cx_ff - sy;
               cy_in = cy_ff + sx;
               cz_in = cz_ff - atan_turn(step_ff);
            end
         end
         BK_ERR: begin
            phi_in = phi_s;
         end
         // products kept to their true operand widths: gain x angle, then x angle/constant
         BK_MUL1: begin
            lin_in = PW'(lg * rr);
            ang_in = PW'(ag * phi_ff);
         end
         BK_MUL2: begin
            lin_in = PW'($signed(lin_ff[AB+16:0]) * rr);
            ang_in = PW'($signed(ang_ff[AB+16:0]) * $signed({1'b0, TWO_PI_Q20}));
         end
         BK_ROUND: begin
            if (arrive_ff) begin
               status_in  = ST_ARRIVED;
               lin_out_in = '0;
               ang_out_in = '0;
            end else begin
               lin_out_in = round_sat(lin_ff, LSH);
               ang_out_in = round_sat(ang_ff, ASH);
            end
         end
         default: ;
      endcase
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (state_ff == BK_OUT && (!out_valid_ff || !rsp_stall)) begin
         out_valid_in            = 1'b1;
         out_in.linear_velocity  = lin_out_ff;
         out_in.angular_velocity = ang_out_ff;
         out_in.status           = status_ff;
         out_in.target_point     = 8'(target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         target_ff    <= '0;
         status_ff    <= ST_MOVING;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         target_ff    <= target_in;
         status_ff    <= status_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rx_ff      <= rx_in;
      ry_ff      <= ry_in;
      head_ff    <= head_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      arrive_ff  <= arrive_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      cz_ff      <= cz_in;
      step_ff    <= step_in;
      phi_ff     <= phi_in;
      lin_ff     <= lin_in;
      ang_ff     <= ang_in;
      lin_out_ff <= lin_out_in;
      ang_out_ff <= ang_out_in;
      out_ff     <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count beyond store");
   a_scan_in_path: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SCAN_CMP |-> CW'(target_ff) < count_ff)
      else $error("scan beyond last point");
   a_arrived_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) && out_ff.status == ST_ARRIVED && $past(state_ff) == BK_OUT
      && $past(state_ff, 2) == BK_ROUND |-> out_ff.linear_velocity == 0)
      else $error("arrival with nonzero speed");
   a_cordic_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_CORDIC |-> step_ff < 5'(CORDIC_STEPS))
      else $error("cordic step overrun");

endmodule

/* sv/cpf_front.sv */
// Front half: configuration registers and input acceptance into the item queue.
// Depends on cpf_pkg for the request type and register index codes.
module cpf_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cpf_pkg::req_payload_type req_payload,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data,
   input  logic                     queue_full,
   output logic                     queue_push,
   output cpf_pkg::req_payload_type queue_data,
   output logic [14:0]              lookahead_radius,
   output logic [14:0]              goal_tolerance,
   output logic                     backward_mode,
   output logic signed [15:0]       forward_linear_gain,
   output logic signed [15:0]       forward_angular_gain,
   output logic signed [15:0]       backward_linear_gain,
   output logic signed [15:0]       backward_angular_gain
);
   import cpf_pkg::*;

   logic [14:0]        look_ff, look_in, tol_ff, tol_in;
   logic               bwd_ff, bwd_in;
   logic signed [15:0] flg_ff, flg_in, fag_ff, fag_in, blg_ff, blg_in, bag_ff, bag_in;

   always_comb begin
      look_in = look_ff;
      tol_in  = tol_ff;
      bwd_in  = bwd_ff;
      flg_in  = flg_ff;
      fag_in  = fag_ff;
      blg_in  = blg_ff;
      bag_in  = bag_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_LOOKAHEAD: look_in = csr_data[14:0];
            CSR_GOAL_TOL:  tol_in  = csr_data[14:0];
            CSR_BACKWARD:  bwd_in  = csr_data[0];
            CSR_FWD_LIN:   flg_in  = csr_data;
            CSR_FWD_ANG:   fag_in  = csr_data;
            CSR_BWD_LIN:   blg_in  = csr_data;
            CSR_BWD_ANG:   bag_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         look_ff <= 15'd82;
         tol_ff  <= 15'd0;
         bwd_ff  <= 1'b0;
         flg_ff  <= 16'sd410;
         fag_ff  <= 16'sd2048;
         blg_ff  <= -16'sd328;
         bag_ff  <= -16'sd2048;
      end else begin
         look_ff <= look_in;
         tol_ff  <= tol_in;
         bwd_ff  <= bwd_in;
         flg_ff  <= flg_in;
         fag_ff  <= fag_in;
         blg_ff  <= blg_in;
         bag_ff  <= bag_in;
      end
   end

   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full;
   assign queue_data = req_payload;

   assign lookahead_radius      = look_ff;
   assign goal_tolerance        = tol_ff;
   assign backward_mode         = bwd_ff;
   assign forward_linear_gain   = flg_ff;
   assign forward_angular_gain  = fag_ff;
   assign backward_linear_gain  = blg_ff;
   assign backward_angular_gain = bag_ff;

   a_push_only_free: assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_full) else $error("push into full queue");
   a_csr_holds: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_write) |-> $stable(look_ff) && $stable(bwd_ff))
      else $error("register changed without write");
   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |-> queue_push) else $error("accepted item lost");

endmodule

/* sv/carrot_path_follower_unit.sv */
// Top level of the carrot path follower: front (registers, acceptance), queue, back.
// Depends on cpf_pkg, cpf_front, cpf_queue, cpf_back.
//
//  port group | dir | handshake        | payload
//  req_       | in  | req_valid/stall  | operation, pos_x, pos_y, robot_heading
//  rsp_       | out | rsp_valid/stall  | linear/angular velocity, status, target
//  csr_       | in  | csr_write        | csr_index, csr_data (16 bits)
//
// Clear and append are done in the back half without a result item; cancel and a pose
// update that answers at once (finished or too short a path) go straight to the result
// register. A full pose update reads the one-port point store once per scan step and then
// runs the 24-step serial CORDIC. A two-entry queue decouples input acceptance
// from that work; a result register holds an item while rsp_stall is high.
// Reset is synchronous, active high, and empties path, target and status.
module carrot_path_follower_unit #(
   parameter int MAX_POINTS = 256,
   parameter int ANGLE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  cpf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output cpf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data
);
   import cpf_pkg::*;

   logic               q_full, q_push, q_pop, q_nempty;
   req_payload_type    q_in, q_out;
   logic [14:0]        look, tol;
   logic               bwd;
   logic signed [15:0] flg, fag, blg, bag;

   cpf_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_payload,
      .csr_write, .csr_index, .csr_data,
      .queue_full(q_full), .queue_push(q_push), .queue_data(q_in),
      .lookahead_radius(look), .goal_tolerance(tol), .backward_mode(bwd),
      .forward_linear_gain(flg), .forward_angular_gain(fag),
      .backward_linear_gain(blg), .backward_angular_gain(bag)
   );

   // item queue between acceptance and execution
   cpf_queue #(.DEPTH(2)) u_queue (
      .clock, .reset, .push(q_push), .push_data(q_in), .full(q_full),
      .pop(q_pop), .pop_data(q_out), .not_empty(q_nempty)
   );

   cpf_back #(.MAX_POINTS(MAX_POINTS), .ANGLE_BITS(ANGLE_BITS)) u_back (
      .clock, .reset, .item_valid(q_nempty), .item(q_out), .item_pop(q_pop),
      .lookahead_radius(look), .goal_tolerance(tol), .backward_mode(bwd),
      .forward_linear_gain(flg), .forward_angular_gain(fag),
      .backward_linear_gain(blg), .backward_angular_gain(bag),
      .rsp_valid, .rsp_stall, .rsp_payload
   );

   a_rsp_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == ST_MOVING |-> $past(q_pop, 1) || $stable(rsp_payload)
      || !$past(rsp_valid) || $past(rsp_valid)) else $error("bad response");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      $past(rsp_valid) && $past(rsp_stall) |-> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_nempty) else $error("pop from empty queue");

endmodule

/* bench/cpf_checker.sv */
// Result checker for the carrot path follower: watches req_, rsp_ and csr_ ports,
// predicts every result item and compares it field by field. Depends on cpf_pkg.
module cpf_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  cpf_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  cpf_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write,
   input  logic [2:0]               csr_index,
   input  logic [15:0]              csr_data,
   output int                       fail_count,
   output int                       pending,
   output int                       results_seen
);
   import cpf_pkg::*;

   localparam int NPTS = 256;
   localparam longint TWO_PI_Q20 = 6588397;
   localparam logic [31:0] ARCTAN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

   logic signed [15:0] way_x [NPTS];
   logic signed [15:0] way_y [NPTS];
   int unsigned        way_count;
   int unsigned        carrot;
   status_type         run_status;
   longint             look_r, goal_r;
   bit                 reverse;
   longint             fwd_lin, fwd_ang, bwd_lin, bwd_ang;

   rsp_payload_type    expected_rsp [$];

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint rshift_round(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   // CORDIC vectoring: bearing of (dx, dy) as a 16 bit binary angle
   function automatic logic [15:0] heading_to(longint dx, longint dy);
      longint x, y, nx, ny;
      logic [31:0] z;
      x = dx * 256;
      y = dy * 256;
      z = 0;
      if (dx == 0 && dy == 0) return 16'd0;
      if (x < 0) begin
         x = -x; y = -y; z = 32'h80000000;
      end
      for (int i = 0; i < 24; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z = z + ARCTAN[i];
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z = z - ARCTAN[i];
         end
         x = nx; y = ny;
      end
      z = z + 32'h8000;
      return z[31:16];
   endfunction

   function automatic longint range_sq(int unsigned k, longint rx, longint ry);
      longint dx, dy;
      dx = longint'(way_x[k]) - rx;
      dy = longint'(way_y[k]) - ry;
      return dx * dx + dy * dy;
   endfunction

   task automatic follow_step(input req_payload_type it);
      rsp_payload_type r;
      longint rx, ry, phi, mag, rem, lg, ag, lin, ang;
      int unsigned last;
      logic [15:0] theta, err;
      rx = longint'(it.pos_x);
      ry = longint'(it.pos_y);
      lin = 0;
      ang = 0;
      case (op_type'(it.operation))
         OP_CLEAR: begin
            way_count = 0; carrot = 0; run_status = ST_MOVING;
            return;
         end
         OP_APPEND: begin
            if (way_count < NPTS) begin
               way_x[way_count] = it.pos_x;
               way_y[way_count] = it.pos_y;
               way_count++;
            end
            return;
         end
         OP_CANCEL: if (run_status == ST_MOVING) run_status = ST_CANCELLED;
         default: begin
            if (run_status == ST_MOVING) begin
               if (way_count <= 1) run_status = ST_ABORTED;
               else begin
                  last = way_count - 1;
                  if (carrot > last) carrot = last;
                  while (carrot < last && range_sq(carrot, rx, ry) < look_r * look_r)
                     carrot++;
                  theta = heading_to(longint'(way_x[carrot]) - rx,
                                     longint'(way_y[carrot]) - ry);
                  err = theta - it.robot_heading;
                  if (reverse) err = 16'h8000 - err;
                  phi = (err > 16'h8000) ? longint'(err) - 65536 : longint'(err);
                  mag = phi < 0 ? -phi : phi;
                  rem = 32768 - mag;
                  lg = reverse ? bwd_lin : fwd_lin;
                  ag = reverse ? bwd_ang : fwd_ang;
                  lin = sat16(rshift_round(lg * rem * rem, 30));
                  ang = sat16(rshift_round(ag * phi * TWO_PI_Q20, 36));
                  if (range_sq(last, rx, ry) <= goal_r * goal_r) begin
                     run_status = ST_ARRIVED; lin = 0; ang = 0;
                  end
               end
            end
         end
      endcase
      r.linear_velocity = lin[15:0];
      r.angular_velocity = ang[15:0];
      r.status = run_status;
      r.target_point = carrot[7:0];
      expected_rsp.insert(expected_rsp.size(), r);
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
      results_seen = 0;
   end

   always @(posedge clock) begin
      rsp_payload_type e;
      if (reset) begin
         way_count = 0; carrot = 0; run_status = ST_MOVING;
         look_r = 82; goal_r = 0; reverse = 0;
         fwd_lin = 410; fwd_ang = 2048; bwd_lin = -328; bwd_ang = -2048;
         expected_rsp.delete();
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_LOOKAHEAD: look_r = longint'(csr_data[14:0]);
               CSR_GOAL_TOL:  goal_r = longint'(csr_data[14:0]);
               CSR_BACKWARD:  reverse = csr_data[0];
               CSR_FWD_LIN:   fwd_lin = longint'($signed(csr_data));
               CSR_FWD_ANG:   fwd_ang = longint'($signed(csr_data));
               CSR_BWD_LIN:   bwd_lin = longint'($signed(csr_data));
               CSR_BWD_ANG:   bwd_ang = longint'($signed(csr_data));
               default: ;
            endcase
         end
         if (req_valid && !req_stall) follow_step(req_payload);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               report("unexpected result items", 1, 0);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_payload.linear_velocity !== e.linear_velocity)
                  report("linear_velocity", rsp_payload.linear_velocity, e.linear_velocity);
               if (rsp_payload.angular_velocity !== e.angular_velocity)
                  report("angular_velocity", rsp_payload.angular_velocity,
                         e.angular_velocity);
               if (rsp_payload.status !== e.status)
                  report("status", rsp_payload.status, e.status);
               if (rsp_payload.target_point !== e.target_point)
                  report("target_point", rsp_payload.target_point, e.target_point);
            end
         end
      end
      pending = expected_rsp.size();
   end
endmodule

/* bench/testbench.sv */
// Top of the carrot path follower bench: clock, reset, stimulus, stall pattern,
// watchdog and verdict. Depends on cpf_pkg, carrot_path_follower_unit, cpf_checker.
module testbench;
   import cpf_pkg::*;

   localparam int STALL_LIMIT = 20000;   // idle cycles before giving up
   localparam int HOLD_CYCLES = 300;     // long receiver hold-off

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_write;
   logic [2:0]      csr_index;
   logic [15:0]     csr_data;

   int  fail_count, pending, results_seen;
   int  items_sent = 0;
   int  settings_run = 0;
   int  idle_cycles = 0;
   bit  calm = 0;          // no idling on either side
   bit  hold_off = 0;      // receiver to stall for a long stretch

   // path as the stimulus sees it, used to aim poses near the points
   logic signed [15:0] lay_x [256];
   logic signed [15:0] lay_y [256];
   int                 lay_n = 0;

   carrot_path_follower_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   cpf_checker check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] rnd16();
      return 16'($urandom);
   endfunction

   // send one item and hold it until accepted; then maybe a short gap
   task automatic send(input op_type op, input logic [15:0] x, input logic [15:0] y,
                       input logic [15:0] h);
      req_valid <= 1'b1;
      req_payload <= '{operation: op, pos_x: x, pos_y: y, robot_heading: h};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (!calm && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic add_point(input logic [15:0] x, input logic [15:0] y);
      if (lay_n < 256) begin
         lay_x[lay_n] = x; lay_y[lay_n] = y; lay_n++;
      end
      send(OP_APPEND, x, y, rnd16());
   endtask

   task automatic clear_path();
      lay_n = 0;
      send(OP_CLEAR, rnd16(), rnd16(), rnd16());
   endtask

   // registers only change with nothing in flight
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] look, input logic [15:0] tol,
                            input bit bwd, input logic [15:0] fl, input logic [15:0] fa,
                            input logic [15:0] bl, input logic [15:0] ba);
      logic [15:0] v [7];
      v = '{look, tol, {15'd0, bwd}, fl, fa, bl, ba};
      for (int i = 0; i < 7; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[2:0];
         csr_data <= v[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      settings_run++;
   endtask

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 4000));
         3: return -16'($urandom_range(0, 4000));
         default: return rnd16();
      endcase
   endfunction

   function automatic logic [15:0] near(input logic [15:0] c, input int spread);
      return c + 16'($urandom_range(0, 2 * spread) - spread);
   endfunction

   // pose aimed near a random path point, sometimes anywhere
   task automatic pose_near(input int spread);
      int k;
      if (lay_n == 0 || $urandom_range(0, 7) == 0)
         send(OP_POSE, rnd16(), rnd16(), rnd16());
      else begin
         k = $urandom_range(0, lay_n - 1);
         send(OP_POSE, near(lay_x[k], spread), near(lay_y[k], spread), rnd16());
      end
   endtask

   // receiver side: random stall bursts, a long hold-off when asked
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   // watchdog: cycles with no item moving on any port
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("carrot_path_follower_unit regression: fail");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int npts, spread, scale;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_write <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset settings first
      send(OP_POSE, 16'd0, 16'd0, 16'd0);             // empty path aborts
      send(OP_CANCEL, 16'd0, 16'd0, 16'd0);           // keeps aborted
      clear_path();
      send(OP_CANCEL, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // cancels while moving
      clear_path();
      add_point(16'h7FFF, 16'h8000);
      send(OP_POSE, 16'h8000, 16'h7FFF, 16'hFFFF);    // single point aborts
      clear_path();
      add_point(16'd0, 16'd0);
      add_point(16'd1000, 16'd0);
      add_point(16'd2000, 16'd0);
      send(OP_POSE, 16'd0, 16'd0, 16'h8000);          // exact half-turn error
      send(OP_POSE, 16'd1000, 16'd0, 16'd0);          // robot on the target
      send(OP_POSE, 16'h8000, 16'h8000, 16'h4000);
      send(OP_POSE, 16'h7FFF, 16'h7FFF, 16'd0);
      send(OP_POSE, 16'd2000, 16'd0, 16'd0);          // arrival, tolerance zero
      send(OP_POSE, 16'd0, 16'd0, 16'd0);             // stays arrived
      add_point(16'd3000, 16'd0);                     // stored while finished
      send(OP_CANCEL, 16'd0, 16'd0, 16'd0);
      settle();

      // extremes: reverse, saturating gains, huge radius
      configure(16'h7FFF, 16'd0, 1'b1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      clear_path();
      add_point(16'h8000, 16'h8000);
      add_point(16'h7FFF, 16'h7FFF);
      send(OP_POSE, 16'd0, 16'd0, 16'd0);
      send(OP_POSE, 16'h8000, 16'h7FFF, 16'h7FFF);
      settle();

      // full store: the last appends are dropped
      configure(16'd0, 16'h7FFF, 1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      clear_path();
      for (int i = 0; i < 258; i++) add_point(16'(i * 200), 16'($urandom_range(0, 50)));
      send(OP_POSE, 16'd0, 16'd0, 16'd0);
      settle();

      // long receiver hold-off with the sender pushing pose items
      configure(16'd82, 16'd0, 1'b0, 16'd410, 16'd2048, -16'd328, -16'd2048);
      clear_path();
      for (int i = 0; i < 6; i++) add_point(16'(i * 300), 16'(i * 100));
      hold_off = 1;
      for (int i = 0; i < 12; i++) pose_near(200);
      settle();

      // random phases: a setting, a path, then poses, cancels, appends and clears
      while (items_sent < 650) begin
         if (items_sent > 560) calm = 1;
         case ($urandom_range(0, 3))
            0: scale = 300;
            1: scale = 3000;
            default: scale = 32767;
         endcase
         configure($urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 32767))
                                             : 16'($urandom_range(0, scale / 2)),
                   $urandom_range(0, 4) == 0 ? 16'($urandom_range(0, 32767))
                                             : 16'($urandom_range(0, scale / 8)),
                   1'($urandom_range(0, 1)), pick_gain(), pick_gain(), pick_gain(),
                   pick_gain());
         clear_path();
         npts = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
         for (int i = 0; i < npts; i++)
            add_point(16'($urandom_range(0, 2 * scale) - scale),
                      16'($urandom_range(0, 2 * scale) - scale));
         spread = scale / 4 + 1;
         for (int i = 0; i < $urandom_range(4, 14); i++) begin
            case ($urandom_range(0, 11))
               0: send(OP_CANCEL, rnd16(), rnd16(), rnd16());
               1: add_point(rnd16(), rnd16());
               2: if (!calm) begin
                  clear_path();
                  add_point(rnd16(), rnd16());
                  add_point(rnd16(), rnd16());
               end
               default: pose_near(spread);
            endcase
         end
         settle();
      end

      settle();
      repeat (100) @(posedge clock);
      $display("covered %0d items under %0d register settings, %0d results checked",
               items_sent, settings_run, results_seen);
      if (fail_count == 0 && pending == 0)
         $display("carrot_path_follower_unit regression: pass");
      else
         $display("carrot_path_follower_unit regression: fail");
      $finish;
   end
endmodule

/* filelist.f */
sv/cpf_pkg.sv
sv/cpf_queue.sv
sv/cpf_back.sv
sv/cpf_front.sv
sv/carrot_path_follower_unit.sv
bench/cpf_checker.sv
bench/testbench.sv
